// ----- rtl/double_ended_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Double-ended queue unit: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("double-ended queue port check failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("double-ended queue port check failed");

`endif

// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request and result types, command and status codes, default ring depth.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Default number of ring entries.
	localparam int DEPTH_DEF = 16;

	// Width of one stored value.
	localparam int DATA_W = 32;

	// Command codes.
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_REAR   = 3'd3;
	localparam logic [2:0] CMD_LIST       = 3'd4;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// One request.
	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	// One result.
	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] item_value;
		logic                     last;
	} rsp_t;

endpackage

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue ring memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic signed [deq_pkg::DATA_W-1:0] wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic signed [deq_pkg::DATA_W-1:0] rdata
);
	import deq_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of signed 32-bit values held in a ring memory, addressed by
// a head pointer and a fill count.
//
//   channel   signals               direction   handshake
//   request   start, busy, req      in          taken when start and not busy
//   result    done, rsp             out         each result valid for one cycle, no stall
//
// A push or pop request is taken in one cycle; its single result appears
// in the next cycle, and a new request may be taken in that same cycle.
// A list request produces one result per stored element, one per cycle,
// paced by the single memory read port; busy stays high until the final one.
// Reset clears the head pointer, the fill count and the control state; the
// ring memory holds no reset value, and an entry never written never reaches rsp.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  deq_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output deq_pkg::rsp_t rsp
);
	import deq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]   em_q, em_d;
	logic               done_q, done_d;
	logic               use_rd_q, use_rd_d;
	logic [1:0]         status_q, status_d;
	logic signed [DATA_W-1:0] value_q, value_d;

	logic               accept;
	logic               is_empty;
	logic               is_full;
	logic               list_last;
	logic [PTR_W-1:0]   head_m1;
	logic [PTR_W-1:0]   head_p1;
	logic [PTR_W-1:0]   rear_pos;
	logic [PTR_W-1:0]   last_pos;
	logic [PTR_W-1:0]   rd_ptr_p1;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_raddr;
	logic signed [DATA_W-1:0] ram_rdata;

	// Fold a position below twice the depth back into the ring.
	function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
		return r[PTR_W-1:0];
	endfunction

	// Queue status and ring positions.
	assign accept    = start && !busy;
	assign is_empty  = (cnt_q == '0);
	assign is_full   = (cnt_q == CNT_W'(DEPTH));
	assign list_last = (state_q == S_LIST) && ((CNT_W'(em_q) + CNT_W'(1)) == cnt_q);
	assign busy      = (state_q == S_LIST) && !list_last;

	assign head_m1   = (head_q == '0) ? PTR_W'(DEPTH - 1) : (head_q - PTR_W'(1));
	assign head_p1   = wrap(SUM_W'(head_q) + SUM_W'(1));
	assign rear_pos  = wrap(SUM_W'(head_q) + SUM_W'(cnt_q));
	assign last_pos  = wrap(SUM_W'(head_q) + SUM_W'(cnt_q) - SUM_W'(1));
	assign rd_ptr_p1 = wrap(SUM_W'(rd_ptr_q) + SUM_W'(1));

	// Request decode, memory access and next state.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		rd_ptr_d  = rd_ptr_q;
		em_d      = em_q;
		done_d    = 1'b0;
		use_rd_d  = 1'b0;
		status_d  = STAT_OK;
		value_d   = req.push_value;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;

		// A running list reads one element ahead of the one on the outputs.
		if (state_q == S_LIST) begin
			ram_re   = 1'b1;
			rd_ptr_d = rd_ptr_p1;
			em_d     = em_q + PTR_W'(1);
			if (list_last) begin
				state_d = S_IDLE;
			end
		end

		if (accept) begin
			unique case (req.cmd)
				CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
					done_d = 1'b1;
					if (is_full) begin
						status_d = STAT_FULL;
						value_d  = '0;
					end else begin
						ram_we = 1'b1;
						cnt_d  = cnt_q + CNT_W'(1);
						if (req.cmd == CMD_PUSH_FRONT) begin
							ram_waddr = head_m1;
							head_d    = head_m1;
						end else begin
							ram_waddr = rear_pos;
						end
					end
				end
				CMD_POP_FRONT, CMD_POP_REAR: begin
					done_d = 1'b1;
					if (is_empty) begin
						status_d = STAT_EMPTY;
						value_d  = '0;
					end else begin
						ram_re   = 1'b1;
						use_rd_d = 1'b1;
						cnt_d    = cnt_q - CNT_W'(1);
						if (req.cmd == CMD_POP_FRONT) begin
							ram_raddr = head_q;
							head_d    = head_p1;
						end else begin
							ram_raddr = last_pos;
						end
					end
				end
				CMD_LIST: begin
					if (is_empty) begin
						done_d   = 1'b1;
						status_d = STAT_EMPTY;
						value_d  = '0;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = head_q;
						rd_ptr_d  = head_p1;
						em_d      = '0;
						state_d   = S_LIST;
					end
				end
				default: begin
					// Unused codes are taken and dropped.
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			em_q     <= '0;
			done_q   <= 1'b0;
			use_rd_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			cnt_q    <= cnt_d;
			rd_ptr_q <= rd_ptr_d;
			em_q     <= em_d;
			done_q   <= done_d;
			use_rd_q <= use_rd_d;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		status_q <= status_d;
		value_q  <= value_d;
	end

	// Ring storage.
	deq_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.push_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result outputs: a list streams memory data, other requests use the
	// registered result.
	always_comb begin
		if (state_q == S_LIST) begin
			done           = 1'b1;
			rsp.status     = STAT_OK;
			rsp.item_value = ram_rdata;
			rsp.last       = list_last;
		end else begin
			done           = done_q;
			rsp.status     = status_q;
			rsp.item_value = use_rd_q ? ram_rdata : value_q;
			rsp.last       = 1'b1;
		end
	end

endmodule

// ----- rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_macros.svh"

module deq_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input deq_pkg::req_t req,
	input logic          busy,
	input logic          done,
	input deq_pkg::rsp_t rsp
);
	import deq_pkg::*;

	logic                     push_taken;
	logic                     push_pop_taken;
	logic                     err_result;
	logic                     stream_result;
	logic                     echo_ok;
	logic signed [DATA_W-1:0] push_value_q;

	// Requests taken this cycle, by kind.
	assign push_taken     = start && !busy &&
		(req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_REAR);
	assign push_pop_taken = push_taken || (start && !busy &&
		(req.cmd == CMD_POP_FRONT || req.cmd == CMD_POP_REAR));

	// Shapes of the result on the outputs.
	assign err_result    = done && (rsp.status != STAT_OK);
	assign stream_result = done && !rsp.last && (rsp.status == STAT_OK);

	// Value offered with the request of the previous cycle.
	always_ff @(posedge clk) begin
		push_value_q <= req.push_value;
	end

	assign echo_ok = (rsp.status == STAT_FULL) ||
		(rsp.status == STAT_OK && rsp.item_value == push_value_q);

	// A result that is not ok carries a zero value and closes its request.
	`DEQ_ASSERT_SAME(a_err_value_zero, clk, arst_n, err_result, rsp.item_value == '0 && rsp.last)

	// The unit is only busy while a list is streaming results.
	`DEQ_ASSERT_SAME(a_busy_streams, clk, arst_n, busy, stream_result)

	// A push or pop answers with one final result in the next cycle.
	`DEQ_ASSERT_NEXT(a_single_result, clk, arst_n, push_pop_taken, done && rsp.last)

	// An accepted push echoes its value unless it was refused.
	`DEQ_ASSERT_NEXT(a_push_echo, clk, arst_n, push_taken, echo_ok)

endmodule

bind double_ended_queue_unit deq_port_checker u_deq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.req   (req),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

// ----- tb/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches the request and result channels of the queue unit. It keeps its
// own copy of the ring, head and fill count, works out the results of every
// accepted request and compares each result with the oldest one pending.
// ----------------------------------------------------------------------------
module deq_checker #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  deq_pkg::req_t req,
	input  logic          done,
	input  deq_pkg::rsp_t rsp,
	output int            mismatch_cnt,
	output int            waiting_cnt
);
	import deq_pkg::*;

	// Mirror of the queue contents.
	logic signed [DATA_W-1:0] ring_mirror [DEPTH];
	int front_pos;
	int occupancy;

	// Results still owed by the unit, oldest first.
	rsp_t pending_results [$];
	int   fail_tally = 0;

	function automatic rsp_t make_result(logic [1:0] st, logic signed [DATA_W-1:0] v,
		logic fin);
		rsp_t r;
		r.status     = st;
		r.item_value = v;
		r.last       = fin;
		return r;
	endfunction

	// Apply one request to the mirror and queue up the results it causes.
	task automatic apply_request(input req_t r);
		int pos;
		int i;
		case (r.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (occupancy >= DEPTH) begin
					pending_results.push_back(make_result(STAT_FULL, '0, 1'b1));
				end else begin
					if (r.cmd == CMD_PUSH_FRONT) begin
						front_pos = (front_pos + DEPTH - 1) % DEPTH;
						pos = front_pos;
					end else begin
						pos = (front_pos + occupancy) % DEPTH;
					end
					ring_mirror[pos] = r.push_value;
					occupancy++;
					pending_results.push_back(make_result(STAT_OK, r.push_value, 1'b1));
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (occupancy == 0) begin
					pending_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
				end else begin
					if (r.cmd == CMD_POP_FRONT) begin
						pos = front_pos;
						front_pos = (front_pos + 1) % DEPTH;
					end else begin
						pos = (front_pos + occupancy - 1) % DEPTH;
					end
					occupancy--;
					pending_results.push_back(make_result(STAT_OK, ring_mirror[pos], 1'b1));
				end
			end
			CMD_LIST: begin
				if (occupancy == 0) begin
					pending_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
				end else begin
					for (i = 0; i < occupancy; i++) begin
						pos = (front_pos + i) % DEPTH;
						pending_results.push_back(make_result(STAT_OK, ring_mirror[pos],
							i == occupancy - 1));
					end
				end
			end
			default: begin
				// Unused command codes leave the queue alone and give no result.
			end
		endcase
	endtask

	// Results are checked before the request of the same edge is applied, since
	// a request never gets its result in the cycle it is taken.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			front_pos = 0;
			occupancy = 0;
			pending_results.delete();
			waiting_cnt  <= 0;
			mismatch_cnt <= fail_tally;
		end else begin
			if (done !== 1'b0) begin
				if (pending_results.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("unexpected result: status=%0d value=%0d last=%0d",
							rsp.status, rsp.item_value, rsp.last);
				end else begin
					want = pending_results.pop_front();
					if (rsp.status !== want.status || rsp.item_value !== want.item_value ||
						rsp.last !== want.last) begin
						fail_tally++;
						if (fail_tally <= 10)
							$display("result mismatch: expected status=%0d value=%0d last=%0d, got status=%0d value=%0d last=%0d",
								want.status, want.item_value, want.last,
								rsp.status, rsp.item_value, rsp.last);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				apply_request(req);
			waiting_cnt  <= pending_results.size();
			mismatch_cnt <= fail_tally;
		end
	end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives directed and random requests into the queue unit with several
// amounts of idling between them, and lets the checker beside the unit
// judge every result.
// ----------------------------------------------------------------------------
module testbench;
	import deq_pkg::*;

	// Command codes the unit must ignore.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	localparam int RANDOM_REQS = 350;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;
	int   mismatch_cnt;
	int   waiting_cnt;
	int   cycle_cnt = 0;
	int   idle_pct = 0;

	double_ended_queue_unit #(
		.DEPTH(DEPTH_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	deq_checker #(
		.DEPTH(DEPTH_DEF)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.mismatch_cnt(mismatch_cnt),
		.waiting_cnt(waiting_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly random values, with the extremes now and then.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Present one request until it is taken, then idle at random with noise
	// on the request bus.
	task automatic send_request(input logic [2:0] cmd, input logic signed [DATA_W-1:0] v);
		start          <= 1'b1;
		req.cmd        <= cmd;
		req.push_value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start          <= 1'b0;
			req.cmd        <= 3'($urandom);
			req.push_value <= $urandom;
			@(posedge clk);
		end
	endtask

	// Hold off until every pending result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (waiting_cnt != 0)
			@(posedge clk);
	endtask

	// One random request with a bias toward filling or draining.
	task automatic send_random(input bit fill_bias);
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			send_request(CMD_LIST, pick_value());
		else if (roll < (fill_bias ? 75 : 30))
			send_request($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
		else
			send_request($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR, pick_value());
	endtask

	initial begin
		int phase;
		int n;
		bit fill_bias;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: both pops and the list report empty.
		send_request(CMD_POP_FRONT, pick_value());
		send_request(CMD_POP_REAR, pick_value());
		send_request(CMD_LIST, pick_value());

		// Extremes at both ends, a listing, then one pop from each end.
		send_request(CMD_PUSH_FRONT, VAL_MAX);
		send_request(CMD_PUSH_REAR, VAL_MIN);
		send_request(CMD_PUSH_FRONT, '1);
		send_request(CMD_PUSH_REAR, '0);
		send_request(CMD_LIST, pick_value());
		send_request(CMD_POP_FRONT, pick_value());
		send_request(CMD_POP_REAR, pick_value());

		// Unused command codes are ignored.
		for (n = CMD_UNUSED_LO; n <= CMD_UNUSED_HI; n++)
			send_request(3'(n), pick_value());

		// Fill the ring, get both pushes refused, and list a full queue.
		for (n = 2; n < DEPTH_DEF; n++)
			send_request(n[0] ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
		send_request(CMD_PUSH_FRONT, pick_value());
		send_request(CMD_PUSH_REAR, pick_value());
		send_request(CMD_LIST, pick_value());
		wait_drained();

		// Random requests in phases of differing sender idling.
		fill_bias = 1'b0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 51;
				2: idle_pct = 29;
				default: idle_pct = 0;
			endcase
			n = 0;
			while (n < RANDOM_REQS / 4) begin
				if ($urandom_range(99) < 3) begin
					send_request(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), pick_value());
				end else begin
					if ($urandom_range(19) == 0)
						fill_bias = ~fill_bias;
					send_random(fill_bias);
					n++;
				end
			end
			wait_drained();
		end

		repeat (DEPTH_DEF + 8) @(posedge clk);
		if (mismatch_cnt == 0 && waiting_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
tb/deq_checker.sv
tb/testbench.sv
